// ===== hdl/acpu_pkg.sv =====
// Shared types and constants for the accumulator machine execute block.
// Opcodes, fault codes, beat payloads and controller/datapath command structs.
// No dependencies.
package acpu_pkg;

    localparam int unsigned WORD_BITS_DEF = 16;

    localparam int unsigned OP_BITS   = 4;
    localparam int unsigned PORT_BITS = 16;
    localparam int unsigned RSEL_BITS = 8;
    localparam int unsigned FLAG_BITS = 4;
    localparam int unsigned CHAR_BITS = 8;

    localparam int unsigned FLAG_ZERO_BIT  = 1;
    localparam int unsigned FLAG_CARRY_BIT = 2;
    localparam int unsigned FLAG_DIVZ_BIT  = 3;

    // PC advance per instruction length
    localparam int unsigned PC_STEP_ONE   = 1;
    localparam int unsigned PC_STEP_THREE = 3;
    localparam int unsigned PC_STEP_FOUR  = 4;

    localparam logic [RSEL_BITS-1:0] RSEL_A = 8'd1;
    localparam logic [RSEL_BITS-1:0] RSEL_B = 8'd2;
    localparam logic [RSEL_BITS-1:0] RSEL_C = 8'd3;
    localparam logic [RSEL_BITS-1:0] RSEL_D = 8'd4;

    typedef enum logic [OP_BITS-1:0] {
        OP_LDA  = 4'd0,
        OP_LDB  = 4'd1,
        OP_ADD  = 4'd2,
        OP_SUB  = 4'd3,
        OP_OUTV = 4'd4,
        OP_STA  = 4'd5,
        OP_LDM  = 4'd6,
        OP_JEZ  = 4'd7,
        OP_JNZ  = 4'd8,
        OP_MUL  = 4'd9,
        OP_DIV  = 4'd10,
        OP_INP  = 4'd11,
        OP_LD   = 4'd12,
        OP_HLT  = 4'd13
    } t_op;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_REG  = 2'd1,
        FAULT_OP   = 2'd2
    } t_fault;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_WB
    } t_state;

    typedef struct packed {
        logic [OP_BITS-1:0]   req_type;
        logic [PORT_BITS-1:0] operand_word;
        logic [RSEL_BITS-1:0] reg_select;
        logic [PORT_BITS-1:0] mem_word;
        logic [PORT_BITS-1:0] console_value;
    } t_req_beat;

    typedef struct packed {
        logic [PORT_BITS-1:0] next_pc;
        logic [PORT_BITS-1:0] reg_a_out;
        logic [PORT_BITS-1:0] reg_b_out;
        logic [FLAG_BITS-1:0] flag_bits;
        logic                 write_enable;
        logic [PORT_BITS-1:0] write_address;
        logic [PORT_BITS-1:0] write_data;
        logic                 char_valid;
        logic [CHAR_BITS-1:0] char_out;
        logic                 halted;
        logic [1:0]           fault_code;
    } t_rsp_beat;

    typedef struct packed {
        logic capture;   // latch the accepted beat
        logic prep;      // register product, seed divider
        logic div_step;  // one quotient bit
        logic commit;    // update machine state and load the result register
    } t_cmd;

    typedef struct packed {
        logic div_needed;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/acpu_if.sv =====
// Valid/ready channel interfaces for instruction beats and result beats.
// Depends on acpu_pkg for the payload structs.
interface acpu_req_if import acpu_pkg::*; ();
    logic      valid;
    logic      ready;
    t_req_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface acpu_rsp_if import acpu_pkg::*; ();
    logic      valid;
    logic      ready;
    t_rsp_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/acpu_ctrl.sv =====
// Sequencer for the execute block: accept, prepare, divide loop, write back.
// Depends on acpu_pkg for state, command and status types.
module acpu_ctrl import acpu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.prep = 1'b1;
                n_state    = i_sts.div_needed ? ST_DIV : ST_WB;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                // hold until the result register can take the beat
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/acpu_dpath.sv =====
// Datapath: machine registers, multiplier stage, restoring divider, result register.
// Depends on acpu_pkg; driven by acpu_ctrl through t_cmd / t_sts.
module acpu_dpath import acpu_pkg::*; #(
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_req_beat i_req,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  logic      i_rsp_ready,
    output logic      o_rsp_valid,
    output t_rsp_beat o_rsp
);

    localparam int unsigned CNT_W = $clog2(WORD_BITS);

    // machine state
    logic [WORD_BITS-1:0] r_pc, r_a, r_b, r_c, r_d;
    logic [FLAG_BITS-1:0] r_flags;
    logic                 r_stopped;

    // latched instruction beat
    logic [OP_BITS-1:0]   r_op;
    logic [WORD_BITS-1:0] r_opnd;
    logic [RSEL_BITS-1:0] r_rsel;
    logic [WORD_BITS-1:0] r_mem;
    logic [WORD_BITS-1:0] r_cons;

    logic [2*WORD_BITS-1:0] r_prod;

    logic [WORD_BITS-1:0] r_rem, r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic [WORD_BITS:0]   w_trial_src;
    logic [WORD_BITS:0]   w_trial;

    logic      r_out_valid;
    t_rsp_beat r_out;

    logic [WORD_BITS-1:0] n_pc, n_a, n_b, n_c, n_d;
    logic [FLAG_BITS-1:0] n_flags;
    logic                 n_stopped;
    logic                 w_we, w_cv;
    logic [WORD_BITS-1:0] w_waddr, w_wdata;
    logic [CHAR_BITS-1:0] w_ch;
    t_fault               w_fault;
    logic [WORD_BITS:0]   w_sum;
    logic [WORD_BITS-1:0] w_diff;
    logic [WORD_BITS-1:0] w_pc1, w_pc3, w_pc4;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_req.req_type;
            r_opnd <= WORD_BITS'(i_req.operand_word);
            r_rsel <= i_req.reg_select;
            r_mem  <= WORD_BITS'(i_req.mem_word);
            r_cons <= WORD_BITS'(i_req.console_value);
        end
        if (i_cmd.prep) begin
            r_prod <= (2*WORD_BITS)'(r_a) * (2*WORD_BITS)'(r_b);
        end
    end

    // restoring divide, one quotient bit a cycle, dividend shifts out of r_quo
    assign w_trial_src = {r_rem, r_quo[WORD_BITS-1]};
    assign w_trial     = w_trial_src - {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_rem <= '0;
            r_quo <= r_a;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (!w_trial[WORD_BITS]) begin
                r_rem <= w_trial[WORD_BITS-1:0];
                r_quo <= {r_quo[WORD_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_trial_src[WORD_BITS-1:0];
                r_quo <= {r_quo[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_sts.div_needed = !r_stopped && (t_op'(r_op) == OP_DIV) && (r_b != '0);
    assign o_sts.div_last   = (r_cnt == CNT_W'(WORD_BITS - 1));
    assign o_sts.out_free   = !r_out_valid || i_rsp_ready;

    assign w_sum  = {1'b0, r_a} + {1'b0, r_b};
    assign w_diff = r_a - r_b;
    assign w_pc1  = r_pc + WORD_BITS'(PC_STEP_ONE);
    assign w_pc3  = r_pc + WORD_BITS'(PC_STEP_THREE);
    assign w_pc4  = r_pc + WORD_BITS'(PC_STEP_FOUR);

    always_comb begin
        n_pc      = r_pc;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_d       = r_d;
        n_flags   = r_flags;
        n_stopped = r_stopped;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = '0;
        w_cv      = 1'b0;
        w_ch      = '0;
        w_fault   = FAULT_NONE;
        if (!r_stopped) begin
            unique case (t_op'(r_op))
                OP_LDA: begin
                    n_a  = r_opnd;
                    n_pc = w_pc3;
                end
                OP_LDB: begin
                    n_b  = r_opnd;
                    n_pc = w_pc3;
                end
                OP_ADD: begin
                    n_a                     = w_sum[WORD_BITS-1:0];
                    n_flags[FLAG_ZERO_BIT]  = (w_sum[WORD_BITS-1:0] == '0);
                    n_flags[FLAG_CARRY_BIT] = w_sum[WORD_BITS];
                    n_pc                    = w_pc1;
                end
                OP_SUB: begin
                    n_a                     = w_diff;
                    n_flags[FLAG_ZERO_BIT]  = (w_diff == '0);
                    n_flags[FLAG_CARRY_BIT] = (r_a < r_b);
                    n_pc                    = w_pc1;
                end
                OP_OUTV: begin
                    w_cv = 1'b1;
                    w_ch = r_mem[CHAR_BITS-1:0];
                    n_pc = w_pc3;
                end
                OP_STA: begin
                    w_we    = 1'b1;
                    w_waddr = r_opnd;
                    w_wdata = r_a;
                    n_pc    = w_pc3;
                end
                OP_LDM: begin
                    n_a  = r_mem;
                    n_pc = w_pc3;
                end
                OP_JEZ: begin
                    n_pc = r_flags[FLAG_ZERO_BIT] ? r_opnd : w_pc3;
                end
                OP_JNZ: begin
                    n_pc = r_flags[FLAG_ZERO_BIT] ? w_pc3 : r_opnd;
                end
                OP_MUL: begin
                    n_a                     = r_prod[WORD_BITS-1:0];
                    n_flags[FLAG_ZERO_BIT]  = (r_prod[WORD_BITS-1:0] == '0);
                    n_flags[FLAG_CARRY_BIT] = |r_prod[2*WORD_BITS-1:WORD_BITS];
                    n_pc                    = w_pc1;
                end
                OP_DIV: begin
                    if (r_b == '0) begin
                        n_flags[FLAG_DIVZ_BIT] = 1'b1;
                    end else begin
                        n_flags[FLAG_DIVZ_BIT] = 1'b0;
                        n_a                    = r_quo;
                        n_flags[FLAG_ZERO_BIT] = (r_quo == '0);
                    end
                    n_pc = w_pc1;
                end
                OP_INP: begin
                    w_we    = 1'b1;
                    w_waddr = r_opnd;
                    w_wdata = r_cons;
                    n_pc    = w_pc3;
                end
                OP_LD: begin
                    case (r_rsel)
                        RSEL_A:  n_a = r_mem;
                        RSEL_B:  n_b = r_mem;
                        RSEL_C:  n_c = r_mem;
                        RSEL_D:  n_d = r_mem;
                        default: w_fault = FAULT_REG;
                    endcase
                    n_pc = w_pc4;
                end
                OP_HLT: begin
                    n_stopped = 1'b1;
                end
                default: begin
                    n_stopped = 1'b1;
                    w_fault   = FAULT_OP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_a       <= '0;
            r_b       <= '0;
            r_c       <= '0;
            r_d       <= '0;
            r_flags   <= '0;
            r_stopped <= 1'b0;
        end else if (i_cmd.commit) begin
            r_pc      <= n_pc;
            r_a       <= n_a;
            r_b       <= n_b;
            r_c       <= n_c;
            r_d       <= n_d;
            r_flags   <= n_flags;
            r_stopped <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.next_pc       <= PORT_BITS'(n_pc);
            r_out.reg_a_out     <= PORT_BITS'(n_a);
            r_out.reg_b_out     <= PORT_BITS'(n_b);
            r_out.flag_bits     <= n_flags;
            r_out.write_enable  <= w_we;
            r_out.write_address <= PORT_BITS'(w_waddr);
            r_out.write_data    <= PORT_BITS'(w_wdata);
            r_out.char_valid    <= w_cv;
            r_out.char_out      <= w_ch;
            r_out.halted        <= n_stopped;
            r_out.fault_code    <= w_fault;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

// ===== hdl/accumulator_cpu_execute_top.sv =====
// Top level of the accumulator machine execute block.
// Depends on acpu_pkg, acpu_if, acpu_ctrl and acpu_dpath.
//
//   channel  dir  beat        handshake
//   i_req    in   t_req_beat  valid/ready, one instruction per beat
//   o_rsp    out  t_rsp_beat  valid/ready, one result per instruction
//
// An instruction passes through accept, prepare and write back; DIV with a
// nonzero divisor also runs the bit-serial divider before write back.
// Reset clears PC, A to D, flags and the halted mark, and empties the result register.
// A stalled result holds in its register; the next instruction is still taken and
// waits in write back only while that register is full.
module accumulator_cpu_execute_top import acpu_pkg::*; #(
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    acpu_req_if.sink   i_req,
    acpu_rsp_if.source o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    acpu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (w_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    acpu_dpath #(
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req.payload),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp       (o_rsp.payload)
    );

    assign i_req.ready = w_ready;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for accumulator_cpu_execute_top: instruction beats in, result beats out.
// Predicts each result from an internal model of the machine state; uses acpu_pkg and acpu_if.
// Random idle bursts on both channels, one drain pause, halt or opcode fault only at the very end.
module tb_top;
    import acpu_pkg::*;

    localparam logic [OP_BITS-1:0] OP_BAD_LO = 4'd14;
    localparam logic [OP_BITS-1:0] OP_BAD_HI = 4'd15;

    localparam int RANDOM_ITEMS   = 650;
    localparam int CALM_TAIL      = 60;
    localparam int DRAIN_INDEX    = 340;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        t_req_beat beat;
        bit        drain_first;
    } t_instr_entry;

    logic i_clk;
    logic i_rst_n;

    acpu_req_if req_ch ();
    acpu_rsp_if rsp_ch ();

    accumulator_cpu_execute_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_instr_entry instr_q[$];
    t_rsp_beat    outcome_q[$];

    int issued_cnt;
    int retired_cnt;
    int total_items;
    int mismatch_cnt;
    int gap_left;
    int stall_left;
    int idle_cycles;
    logic calm;

    // Machine state as the bench sees it
    logic [PORT_BITS-1:0] m_pc;
    logic [PORT_BITS-1:0] m_a;
    logic [PORT_BITS-1:0] m_b;
    logic [PORT_BITS-1:0] m_c;
    logic [PORT_BITS-1:0] m_d;
    logic [FLAG_BITS-1:0] m_flags;
    logic                 m_stopped;

    assign calm = (issued_cnt + CALM_TAIL >= total_items);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_rsp_beat execute_instr(t_req_beat r);
        t_rsp_beat            res;
        logic [PORT_BITS:0]   sum;
        logic [2*PORT_BITS-1:0] prod;
        logic                 borrow;
        res = '0;
        res.fault_code = FAULT_NONE;
        if (!m_stopped) begin
            case (r.req_type)
                OP_LDA: begin
                    m_a  = r.operand_word;
                    m_pc = m_pc + PORT_BITS'(PC_STEP_THREE);
                end
                OP_LDB: begin
                    m_b  = r.operand_word;
                    m_pc = m_pc + PORT_BITS'(PC_STEP_THREE);
                end
                OP_ADD: begin
                    sum = {1'b0, m_a} + {1'b0, m_b};
                    m_a = sum[PORT_BITS-1:0];
                    m_flags[FLAG_ZERO_BIT]  = (m_a == '0);
                    m_flags[FLAG_CARRY_BIT] = sum[PORT_BITS];
                    m_pc = m_pc + PORT_BITS'(PC_STEP_ONE);
                end
                OP_SUB: begin
                    borrow = (m_a < m_b);
                    m_a    = m_a - m_b;
                    m_flags[FLAG_ZERO_BIT]  = (m_a == '0);
                    m_flags[FLAG_CARRY_BIT] = borrow;
                    m_pc = m_pc + PORT_BITS'(PC_STEP_ONE);
                end
                OP_OUTV: begin
                    res.char_valid = 1'b1;
                    res.char_out   = r.mem_word[CHAR_BITS-1:0];
                    m_pc = m_pc + PORT_BITS'(PC_STEP_THREE);
                end
                OP_STA: begin
                    res.write_enable  = 1'b1;
                    res.write_address = r.operand_word;
                    res.write_data    = m_a;
                    m_pc = m_pc + PORT_BITS'(PC_STEP_THREE);
                end
                OP_LDM: begin
                    m_a  = r.mem_word;
                    m_pc = m_pc + PORT_BITS'(PC_STEP_THREE);
                end
                OP_JEZ: begin
                    m_pc = m_flags[FLAG_ZERO_BIT] ? r.operand_word
                                                  : m_pc + PORT_BITS'(PC_STEP_THREE);
                end
                OP_JNZ: begin
                    m_pc = m_flags[FLAG_ZERO_BIT] ? m_pc + PORT_BITS'(PC_STEP_THREE)
                                                  : r.operand_word;
                end
                OP_MUL: begin
                    prod = m_a * m_b;
                    m_a  = prod[PORT_BITS-1:0];
                    m_flags[FLAG_ZERO_BIT]  = (m_a == '0);
                    m_flags[FLAG_CARRY_BIT] = (prod[2*PORT_BITS-1:PORT_BITS] != '0);
                    m_pc = m_pc + PORT_BITS'(PC_STEP_ONE);
                end
                OP_DIV: begin
                    // zero divisor: flag it, keep A and the zero flag
                    if (m_b == '0) begin
                        m_flags[FLAG_DIVZ_BIT] = 1'b1;
                    end else begin
                        m_flags[FLAG_DIVZ_BIT] = 1'b0;
                        m_a = m_a / m_b;
                        m_flags[FLAG_ZERO_BIT] = (m_a == '0);
                    end
                    m_pc = m_pc + PORT_BITS'(PC_STEP_ONE);
                end
                OP_INP: begin
                    res.write_enable  = 1'b1;
                    res.write_address = r.operand_word;
                    res.write_data    = r.console_value;
                    m_pc = m_pc + PORT_BITS'(PC_STEP_THREE);
                end
                OP_LD: begin
                    case (r.reg_select)
                        RSEL_A:  m_a = r.mem_word;
                        RSEL_B:  m_b = r.mem_word;
                        RSEL_C:  m_c = r.mem_word;
                        RSEL_D:  m_d = r.mem_word;
                        default: res.fault_code = FAULT_REG;
                    endcase
                    m_pc = m_pc + PORT_BITS'(PC_STEP_FOUR);
                end
                OP_HLT: begin
                    m_stopped = 1'b1;
                end
                default: begin
                    m_stopped      = 1'b1;
                    res.fault_code = FAULT_OP;
                end
            endcase
        end
        m_flags[0]    = 1'b0;
        res.next_pc   = m_pc;
        res.reg_a_out = m_a;
        res.reg_b_out = m_b;
        res.flag_bits = m_flags;
        res.halted    = m_stopped;
        return res;
    endfunction

    function automatic logic [PORT_BITS-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 16'h0001;
            3:       return 16'h8000;
            default: return PORT_BITS'($urandom());
        endcase
    endfunction

    function automatic t_req_beat mk(logic [OP_BITS-1:0] op, logic [PORT_BITS-1:0] opnd,
                                     logic [RSEL_BITS-1:0] rsel, logic [PORT_BITS-1:0] mem,
                                     logic [PORT_BITS-1:0] cons);
        t_req_beat b;
        b.req_type      = op;
        b.operand_word  = opnd;
        b.reg_select    = rsel;
        b.mem_word      = mem;
        b.console_value = cons;
        return b;
    endfunction

    // Random content around a given opcode; mostly legal register numbers
    function automatic t_req_beat rand_instr(logic [OP_BITS-1:0] op);
        logic [RSEL_BITS-1:0] rsel;
        rsel = ($urandom_range(0, 3) != 0) ? RSEL_BITS'($urandom_range(1, 4))
                                           : RSEL_BITS'($urandom_range(0, 255));
        return mk(op, rand_word(), rsel, rand_word(), rand_word());
    endfunction

    task automatic add_instr(t_req_beat b);
        t_instr_entry e;
        e.beat        = b;
        e.drain_first = 1'b0;
        instr_q.push_back(e);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         retired_cnt, name, want, got);
        end
    endtask

    // Driver: present queued instructions, count and predict each accepted beat
    always @(posedge i_clk) begin : drive_req
        int           n_issued;
        t_instr_entry e;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            issued_cnt   <= 0;
            gap_left     = 0;
        end else begin
            n_issued = issued_cnt;
            if (req_ch.valid && req_ch.ready) begin
                outcome_q.push_back(execute_instr(req_ch.payload));
                n_issued++;
                issued_cnt <= n_issued;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else if (instr_q.size() == 0) begin
                    req_ch.valid <= 1'b0;
                end else if (instr_q[0].drain_first && n_issued != retired_cnt) begin
                    // hold until every outstanding result is back
                    req_ch.valid <= 1'b0;
                end else begin
                    e = instr_q.pop_front();
                    req_ch.valid   <= 1'b1;
                    req_ch.payload <= e.beat;
                    if (!calm && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 6);
                end
            end
        end
    end

    // Monitor: random backpressure, compare every result beat with the oldest prediction
    always @(posedge i_clk) begin : watch_rsp
        t_rsp_beat want;
        t_rsp_beat got;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            retired_cnt  <= 0;
            stall_left   = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.payload;
                if (issued_cnt == retired_cnt) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display("result beat with nothing outstanding: 0x%0h", got);
                end else begin
                    want = outcome_q.pop_front();
                    check_field("next_pc",       want.next_pc,       got.next_pc);
                    check_field("reg_a_out",     want.reg_a_out,     got.reg_a_out);
                    check_field("reg_b_out",     want.reg_b_out,     got.reg_b_out);
                    check_field("flag_bits",     want.flag_bits,     got.flag_bits);
                    check_field("write_enable",  want.write_enable,  got.write_enable);
                    check_field("write_address", want.write_address, got.write_address);
                    check_field("write_data",    want.write_data,    got.write_data);
                    check_field("char_valid",    want.char_valid,    got.char_valid);
                    check_field("char_out",      want.char_out,      got.char_out);
                    check_field("halted",        want.halted,        got.halted);
                    check_field("fault_code",    want.fault_code,    got.fault_code);
                    retired_cnt <= retired_cnt + 1;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[accumulator_cpu_execute_top] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int                   n;
        int                   kind;
        logic [OP_BITS-1:0]   op;
        logic [OP_BITS-1:0]   last_op;
        logic [PORT_BITS-1:0] divisor;

        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        mismatch_cnt   = 0;
        total_items    = 1 << 30;
        m_pc = '0; m_a = '0; m_b = '0; m_c = '0; m_d = '0;
        m_flags = '0; m_stopped = 1'b0;

        // Directed: carry, borrow, divide by zero, wide multiply, PC wrap, every LD target
        add_instr(mk(OP_LDA, 16'hFFFF, 8'd0, 16'h0000, 16'h0000));
        add_instr(mk(OP_LDB, 16'h0001, 8'hFF, 16'hFFFF, 16'hFFFF));
        add_instr(mk(OP_ADD, 16'h0000, 8'd0, 16'h0000, 16'h0000));
        add_instr(mk(OP_SUB, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        add_instr(mk(OP_LDB, 16'h0000, 8'd0, 16'h0000, 16'h0000));
        add_instr(mk(OP_DIV, 16'h0000, 8'd0, 16'h0000, 16'h0000));
        add_instr(mk(OP_MUL, 16'h0000, 8'd0, 16'h0000, 16'h0000));
        add_instr(mk(OP_JEZ, 16'hFFFE, 8'd0, 16'h0000, 16'h0000));
        add_instr(mk(OP_LDA, 16'hFFFF, 8'd0, 16'h0000, 16'h0000));
        add_instr(mk(OP_LDB, 16'hFFFF, 8'd0, 16'h0000, 16'h0000));
        add_instr(mk(OP_MUL, 16'h0000, 8'd0, 16'h0000, 16'h0000));
        add_instr(mk(OP_DIV, 16'h0000, 8'd0, 16'h0000, 16'h0000));
        add_instr(mk(OP_JNZ, 16'h1234, 8'd0, 16'h0000, 16'h0000));
        add_instr(mk(OP_JEZ, 16'hFFFF, 8'd0, 16'h0000, 16'h0000));
        add_instr(mk(OP_OUTV, 16'h0000, 8'd0, 16'hABFF, 16'h0000));
        add_instr(mk(OP_STA, 16'hFFFF, 8'd0, 16'h0000, 16'h0000));
        add_instr(mk(OP_LDM, 16'h0000, 8'd0, 16'hFFFF, 16'h0000));
        add_instr(mk(OP_INP, 16'h0000, 8'd0, 16'h0000, 16'hFFFF));
        add_instr(mk(OP_LD, 16'h0000, RSEL_A, 16'h0007, 16'h0000));
        add_instr(mk(OP_LD, 16'h0000, RSEL_B, 16'h0003, 16'h0000));
        add_instr(mk(OP_LD, 16'h0000, RSEL_C, 16'hFFFF, 16'h0000));
        add_instr(mk(OP_LD, 16'h0000, RSEL_D, 16'h8000, 16'h0000));
        add_instr(mk(OP_LD, 16'h0000, 8'd0, 16'h5555, 16'h0000));
        add_instr(mk(OP_LD, 16'h0000, 8'hFF, 16'hAAAA, 16'h0000));
        add_instr(mk(OP_DIV, 16'h0000, 8'd5, 16'h0000, 16'h0000));

        // Random: mostly load/compute/branch sequences, the rest single instructions
        n = 0;
        while (n < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                divisor = ($urandom_range(0, 4) == 0) ? '0 : rand_word();
                add_instr(rand_instr(OP_LDA));
                add_instr(mk(OP_LDB, divisor, 8'($urandom()), rand_word(), rand_word()));
                case ($urandom_range(0, 3))
                    0:       op = OP_ADD;
                    1:       op = OP_SUB;
                    2:       op = OP_MUL;
                    default: op = OP_DIV;
                endcase
                add_instr(rand_instr(op));
                add_instr(rand_instr($urandom_range(0, 1) ? OP_JEZ : OP_JNZ));
                n += 4;
            end else begin
                add_instr(rand_instr(OP_BITS'($urandom_range(0, 12))));
                n++;
            end
        end
        instr_q[DRAIN_INDEX].drain_first = 1'b1;

        // Stop the machine one way or the other, then feed items it must ignore
        case ($urandom_range(0, 2))
            0:       last_op = OP_HLT;
            1:       last_op = OP_BAD_LO;
            default: last_op = OP_BAD_HI;
        endcase
        add_instr(rand_instr(last_op));
        for (int k = 0; k < 10; k++)
            add_instr(rand_instr(OP_BITS'($urandom_range(0, 15))));
        total_items = instr_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (instr_q.size() != 0 || req_ch.valid || issued_cnt != retired_cnt);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (issued_cnt != retired_cnt) begin
            mismatch_cnt++;
            $display("%0d results never arrived", issued_cnt - retired_cnt);
        end
        if (mismatch_cnt == 0)
            $display("[accumulator_cpu_execute_top] OK");
        else
            $display("[accumulator_cpu_execute_top] ERROR");
        $finish;
    end

endmodule

// ===== accumulator_cpu_execute_top.f =====
hdl/acpu_pkg.sv
hdl/acpu_if.sv
hdl/acpu_ctrl.sv
hdl/acpu_dpath.sv
hdl/accumulator_cpu_execute_top.sv
bench/tb_top.sv
